/* rtl/core/clsr_pkg.sv */
// clsr_pkg: shared types and constants for the combined lcg shuffle generator
// used by every module under rtl/core; no dependencies of its own
`default_nettype none

package clsr_pkg;

   // default shuffle table depth
   localparam int TABLE_SIZE_DEF = 32;

   // generator moduli and multipliers
   localparam logic [30:0] MOD1 = 31'd2147483563;
   localparam logic [30:0] MOD2 = 31'd2147483399;
   localparam logic [15:0] MUL1 = 16'd40014;
   localparam logic [15:0] MUL2 = 16'd40692;

   // 2^31 minus each modulus, used to fold the high product bits
   localparam logic [7:0] FOLD1 = 8'd85;
   localparam logic [7:0] FOLD2 = 8'd249;

   // largest output value and reset values
   localparam logic [30:0] OUT_MAX    = 31'd2147483562;
   localparam logic [30:0] SEED_RESET = 31'd1024;
   localparam logic [30:0] G1_RESET   = 31'd1;
   localparam logic [30:0] G2_RESET   = 31'd123456789;

   // which generator an operation belongs to
   typedef enum logic {
      GEN_FIRST,
      GEN_SECOND
   } gen_sel_type;

   // request into the shared modular multiplier
   typedef struct packed {
      logic        valid;
      gen_sel_type sel;
      logic [30:0] operand;
   } mm_req_type;

   // result out of the shared modular multiplier
   typedef struct packed {
      logic        valid;
      gen_sel_type sel;
      logic [30:0] value;
   } mm_rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_INIT,
      ST_SEED_ISSUE,
      ST_SEED_WAIT,
      ST_DRAW_G1,
      ST_DRAW_G2,
      ST_DRAW_WAIT,
      ST_DRAW_READ,
      ST_DRAW_CALC,
      ST_DRAW_OUT
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/combined_lcg_shuffle_rng.sv */
// combined_lcg_shuffle_rng: top level with sequencer, generator state and shuffle memory
// depends on clsr_pkg, clsr_modmul and clsr_slot_div
//
// Usage
//   req channel: one transaction asks for one draw; req_tdata[0] = reseed.
//   rsp channel: one transaction per draw, rsp_tdata[30:0] = value in 1..2147483562.
//   csr port: csr_wr_en writes csr_wr_data as the seed; write only while idle.
// Sequencing
//   a plain draw passes both generator steps through the three-stage modular
//   multiplier back to back, then table read, combine and output load; the next
//   request can be taken in the cycle that rsp_tvalid rises. A reseed first
//   runs the warm-up and fill steps, each a dependent pass through the
//   multiplier. One draw is in flight at a time; req_tready is low until the
//   draw has reached the output register.
// Reset
//   the seed returns to 1024 and a seeding is pending, so the first draw
//   always seeds. The table is not cleared; seeding fills all of it.
// Stalls
//   a response waits in the output register until rsp_tready; a new request
//   is still taken meanwhile and its result is held back until the register frees.
`default_nettype none

module combined_lcg_shuffle_rng #(
   parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_wr_en,
   input  wire  [30:0] csr_wr_data,   // seed_value
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,     // [0] reseed, [7:1] zero fill
   // response stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata      // [30:0] random_value, [31] zero fill
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int STEP_W = $clog2(TABLE_SIZE + 8);
   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(TABLE_SIZE + 7);
   localparam logic [STEP_W-1:0] FILL_START = STEP_W'(8);

   clsr_pkg::state_type state_ff, state_in;

   logic [30:0]       seed_ff;
   logic [30:0]       g1_ff;
   logic [30:0]       g2_ff;
   logic [30:0]       last_out_ff;
   logic              needs_seed_ff;
   logic              g2_seen_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [30:0]       rsp_data_ff;

   logic [30:0] shuf_mem [TABLE_SIZE];
   logic [30:0] tbl_rdata_ff;

   clsr_pkg::mm_req_type mm_req;
   clsr_pkg::mm_rsp_type mm_rsp;

   logic             div_start;
   logic             div_done;
   logic [IDX_W-1:0] slot;

   logic             req_accept;
   logic             out_free;
   logic             seed_load;
   logic             draw_commit;
   logic             out_load;
   logic             cnt_clr;
   logic             g2_clr;
   logic             seed_last;
   logic             tbl_we;
   logic             tbl_re;
   logic [IDX_W-1:0] tbl_waddr;
   logic [30:0]      tbl_wdata;

   logic [30:0]       seed_red;
   logic [30:0]       seed_fix;
   logic [31:0]       diff;
   logic [31:0]       wrapped;
   logic [30:0]       y_val;
   logic [STEP_W-1:0] fill_idx;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign seed_last  = (cnt_ff == LAST_STEP);
   assign fill_idx   = LAST_STEP - cnt_ff;

   // seed cleanup: reduce below the first modulus, zero becomes one
   always_comb begin
      seed_red = (seed_ff >= clsr_pkg::MOD1) ? (seed_ff - clsr_pkg::MOD1) : seed_ff;
      seed_fix = (seed_red == '0) ? 31'd1 : seed_red;
   end

   // draw output: table entry minus second generator, wrapped into range
   always_comb begin
      diff    = {1'b0, tbl_rdata_ff} - {1'b0, g2_ff};
      wrapped = diff + {1'b0, clsr_pkg::OUT_MAX};
      y_val   = (diff[31] || (diff == '0)) ? wrapped[30:0] : diff[30:0];
   end

   // shared units
   clsr_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   clsr_slot_div #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_slot_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (last_out_ff),
      .done     (div_done),
      .quotient (slot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clsr_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tdata[0] || needs_seed_ff) ? clsr_pkg::ST_SEED_INIT
                                                          : clsr_pkg::ST_DRAW_G1;
            end
         end
         clsr_pkg::ST_SEED_INIT:  state_in = clsr_pkg::ST_SEED_ISSUE;
         clsr_pkg::ST_SEED_ISSUE: state_in = clsr_pkg::ST_SEED_WAIT;
         clsr_pkg::ST_SEED_WAIT: begin
            if (mm_rsp.valid) begin
               state_in = seed_last ? clsr_pkg::ST_DRAW_G1 : clsr_pkg::ST_SEED_ISSUE;
            end
         end
         clsr_pkg::ST_DRAW_G1: state_in = clsr_pkg::ST_DRAW_G2;
         clsr_pkg::ST_DRAW_G2: state_in = clsr_pkg::ST_DRAW_WAIT;
         clsr_pkg::ST_DRAW_WAIT: begin
            if (div_done && g2_seen_ff) begin
               state_in = clsr_pkg::ST_DRAW_READ;
            end
         end
         clsr_pkg::ST_DRAW_READ: state_in = clsr_pkg::ST_DRAW_CALC;
         clsr_pkg::ST_DRAW_CALC: state_in = clsr_pkg::ST_DRAW_OUT;
         clsr_pkg::ST_DRAW_OUT: begin
            if (out_free) begin
               state_in = clsr_pkg::ST_IDLE;
            end
         end
         default: state_in = clsr_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready     = 1'b0;
      mm_req.valid   = 1'b0;
      mm_req.sel     = clsr_pkg::GEN_FIRST;
      mm_req.operand = g1_ff;
      div_start      = 1'b0;
      seed_load      = 1'b0;
      draw_commit    = 1'b0;
      out_load       = 1'b0;
      cnt_clr        = 1'b0;
      g2_clr         = 1'b0;
      tbl_we         = 1'b0;
      tbl_re         = 1'b0;
      tbl_waddr      = slot;
      tbl_wdata      = g1_ff;
      unique case (state_ff)
         clsr_pkg::ST_IDLE: begin
            req_tready = !reset;
         end
         clsr_pkg::ST_SEED_INIT: begin
            seed_load = 1'b1;
            cnt_clr   = 1'b1;
         end
         clsr_pkg::ST_SEED_ISSUE: begin
            mm_req.valid = 1'b1;
         end
         clsr_pkg::ST_SEED_WAIT: begin
            // the last TABLE_SIZE warm-up values fill the table top down
            if (mm_rsp.valid && (cnt_ff >= FILL_START)) begin
               tbl_we    = 1'b1;
               tbl_waddr = fill_idx[IDX_W-1:0];
               tbl_wdata = mm_rsp.value;
            end
         end
         clsr_pkg::ST_DRAW_G1: begin
            mm_req.valid = 1'b1;
            div_start    = 1'b1;
            g2_clr       = 1'b1;
         end
         clsr_pkg::ST_DRAW_G2: begin
            mm_req.valid   = 1'b1;
            mm_req.sel     = clsr_pkg::GEN_SECOND;
            mm_req.operand = g2_ff;
         end
         clsr_pkg::ST_DRAW_WAIT: begin
         end
         clsr_pkg::ST_DRAW_READ: begin
            tbl_re = 1'b1;
         end
         clsr_pkg::ST_DRAW_CALC: begin
            draw_commit = 1'b1;
            tbl_we      = 1'b1;
         end
         clsr_pkg::ST_DRAW_OUT: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clsr_pkg::ST_IDLE;
         seed_ff       <= clsr_pkg::SEED_RESET;
         needs_seed_ff <= 1'b1;
         g2_seen_ff    <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         if (state_ff == clsr_pkg::ST_SEED_WAIT && mm_rsp.valid && seed_last) begin
            needs_seed_ff <= 1'b0;
         end
         if (g2_clr) begin
            g2_seen_ff <= 1'b0;
         end else if (mm_rsp.valid && mm_rsp.sel == clsr_pkg::GEN_SECOND) begin
            g2_seen_ff <= 1'b1;
         end
         if (cnt_clr) begin
            cnt_ff <= '0;
         end else if (state_ff == clsr_pkg::ST_SEED_WAIT && mm_rsp.valid) begin
            cnt_ff <= cnt_ff + STEP_W'(1);
         end
      end
   end

   // generator state and last output
   always_ff @(posedge clock) begin
      if (reset) begin
         g1_ff       <= clsr_pkg::G1_RESET;
         g2_ff       <= clsr_pkg::G2_RESET;
         last_out_ff <= '0;
      end else begin
         if (seed_load) begin
            g1_ff <= seed_fix;
            g2_ff <= seed_fix;
         end else if (mm_rsp.valid) begin
            if (mm_rsp.sel == clsr_pkg::GEN_FIRST) begin
               g1_ff <= mm_rsp.value;
            end else begin
               g2_ff <= mm_rsp.value;
            end
         end
         // slot 0 is the last warm-up value; draws overwrite it
         if (state_ff == clsr_pkg::ST_SEED_WAIT && mm_rsp.valid && seed_last) begin
            last_out_ff <= mm_rsp.value;
         end else if (draw_commit) begin
            last_out_ff <= y_val;
         end
      end
   end

   // shuffle memory
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         shuf_mem[tbl_waddr] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_re) begin
         tbl_rdata_ff <= shuf_mem[slot];
      end
   end

   // output data
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= last_out_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

`default_nettype wire

/* rtl/core/clsr_modmul.sv */
// clsr_modmul: shared three-stage unit computing mul * g mod m for either generator
// depends on clsr_pkg for moduli, multipliers and request/response structs
`default_nettype none

module clsr_modmul (
   input  wire                 clock,
   input  wire                 reset,
   input  clsr_pkg::mm_req_type req,
   output clsr_pkg::mm_rsp_type rsp
);

   logic                  s1_valid_ff, s1_valid_in;
   clsr_pkg::gen_sel_type s1_sel_ff, s1_sel_in;
   logic [46:0]           s1_prod_ff, s1_prod_in;

   logic                  s2_valid_ff, s2_valid_in;
   clsr_pkg::gen_sel_type s2_sel_ff, s2_sel_in;
   logic [31:0]           s2_fold_ff, s2_fold_in;

   logic                  s3_valid_ff, s3_valid_in;
   clsr_pkg::gen_sel_type s3_sel_ff, s3_sel_in;
   logic [30:0]           s3_value_ff, s3_value_in;

   logic [15:0] mul_c;
   logic [7:0]  fold_c;
   logic [23:0] hi_scaled;
   logic [31:0] mod_c;

   // stage 1: 16 x 31 product
   always_comb begin
      mul_c       = (req.sel == clsr_pkg::GEN_FIRST) ? clsr_pkg::MUL1 : clsr_pkg::MUL2;
      s1_valid_in = req.valid;
      s1_sel_in   = req.sel;
      s1_prod_in  = {31'd0, mul_c} * {16'd0, req.operand};
   end

   // stage 2: fold bits above 2^31 back in, since 2^31 = c mod m
   always_comb begin
      fold_c      = (s1_sel_ff == clsr_pkg::GEN_FIRST) ? clsr_pkg::FOLD1 : clsr_pkg::FOLD2;
      hi_scaled   = {8'd0, s1_prod_ff[46:31]} * {16'd0, fold_c};
      s2_valid_in = s1_valid_ff;
      s2_sel_in   = s1_sel_ff;
      s2_fold_in  = {1'b0, s1_prod_ff[30:0]} + {8'd0, hi_scaled};
   end

   // stage 3: folded value is below 2m, one conditional subtract finishes it
   always_comb begin
      mod_c       = (s2_sel_ff == clsr_pkg::GEN_FIRST) ? {1'b0, clsr_pkg::MOD1}
                                                       : {1'b0, clsr_pkg::MOD2};
      s3_valid_in = s2_valid_ff;
      s3_sel_in   = s2_sel_ff;
      if (s2_fold_ff >= mod_c) begin
         s3_value_in = 31'(s2_fold_ff - mod_c);
      end else begin
         s3_value_in = s2_fold_ff[30:0];
      end
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // data pipeline
   always_ff @(posedge clock) begin
      s1_sel_ff   <= s1_sel_in;
      s1_prod_ff  <= s1_prod_in;
      s2_sel_ff   <= s2_sel_in;
      s2_fold_ff  <= s2_fold_in;
      s3_sel_ff   <= s3_sel_in;
      s3_value_ff <= s3_value_in;
   end

   assign rsp.valid = s3_valid_ff;
   assign rsp.sel   = s3_sel_ff;
   assign rsp.value = s3_value_ff;

endmodule

`default_nettype wire

/* rtl/core/clsr_slot_div.sv */
// clsr_slot_div: reciprocal multiplier giving the shuffle slot, result ready the cycle after start
// depends on clsr_pkg for the output range constant
`default_nettype none

module clsr_slot_div #(
   parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [30:0]                  dividend,
   output logic                         done,
   output logic [$clog2(TABLE_SIZE)-1:0] quotient
);

   localparam int     IDX_W    = $clog2(TABLE_SIZE);
   localparam longint SLOT_DIV = 1 + longint'(clsr_pkg::OUT_MAX) / TABLE_SIZE;
   // shift of 31 plus the divisor width keeps the quotient exact for any 31-bit dividend
   localparam int     DIV_W    = $clog2(SLOT_DIV);
   localparam int     SHIFT    = 31 + DIV_W;
   localparam longint RECIP_L  = ((longint'(1) << SHIFT) - 1) / SLOT_DIV + 1;
   localparam logic [31:0]      RECIP    = 32'(RECIP_L);
   localparam logic [IDX_W-1:0] TOP_SLOT = IDX_W'(TABLE_SIZE - 1);

   logic [62:0] prod_ff, prod_in;
   logic        done_ff, done_in;
   logic [31:0] quo_wide;

   // dividend times the scaled reciprocal, captured on start
   always_comb begin
      prod_in = start ? ({32'd0, dividend} * {31'd0, RECIP}) : prod_ff;
      done_in = done_ff || start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // upper product bits are the slot, clamped to the top slot
   always_comb begin
      quo_wide = 32'(prod_ff >> SHIFT);
      quotient = (quo_wide > 32'(TABLE_SIZE - 1)) ? TOP_SLOT : quo_wide[IDX_W-1:0];
   end

   assign done = done_ff;

endmodule

`default_nettype wire

/* rtl/core/clsr_checker.sv */
// clsr_checker: port-level checks for combined_lcg_shuffle_rng, bound to the top level
// depends on clsr_pkg for the output range
`default_nettype none

module clsr_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // every response is within 1..OUT_MAX with the fill bit clear
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31] == 1'b0) && (rsp_tdata[30:0] != 31'd0) &&
                     (rsp_tdata[30:0] <= clsr_pkg::OUT_MAX))
      else $error("response value out of range");

   // one draw at a time: no request taken in the cycle after one was taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a draw was in progress");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
